[rtl/core/assert_macros.svh]
// Assertion shorthands for the RTL; all assume clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/dzrs_pkg.sv]
package dzrs_pkg;

  localparam int ZONES  = 7;
  localparam int ZONE_W = 3;
  localparam int TIME_W = 32;
  localparam int SIG_W  = 32;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [ZONE_W-1:0] ZONE_HEADER  = ZONE_W'(0);
  localparam logic [ZONE_W-1:0] ZONE_STATUS  = ZONE_W'(1);
  localparam logic [ZONE_W-1:0] ZONE_GAUGE   = ZONE_W'(2);
  localparam logic [ZONE_W-1:0] ZONE_FIRST_WX = ZONE_W'(4);

  localparam logic [CNT_W-1:0] PCOUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_FULL = 2'd1,
    ACT_PART = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HF_INTERVAL     = 3'd0,
    CFG_STATUS_INTERVAL = 3'd1,
    CFG_GAUGE_INTERVAL  = 3'd2,
    CFG_FULL_INTERVAL   = 3'd3,
    CFG_PARTIALS_MAX    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] header_footer_interval_ms;
    logic [TIME_W-1:0] status_interval_ms;
    logic [TIME_W-1:0] gauge_interval_ms;
    logic [TIME_W-1:0] full_ivl_ms;
    logic [CNT_W-1:0]  partials_max;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]           now_ms;
    logic                        on_weather_screen;
    logic                        full_request;
    logic [ZONES-1:0][SIG_W-1:0] want;
  } tick_t;

  typedef struct packed {
    action_t           action;
    logic [ZONE_W-1:0] zone;
  } result_t;

endpackage

[rtl/core/dzrs_ifs.sv]
interface dzrs_in_if import dzrs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic              on_weather_screen;
  logic              full_request;
  logic [SIG_W-1:0]  want_header;
  logic [SIG_W-1:0]  want_status;
  logic [SIG_W-1:0]  want_gauge;
  logic [SIG_W-1:0]  want_footer;
  logic [SIG_W-1:0]  want_wx_now;
  logic [SIG_W-1:0]  want_wx_forecast;
  logic [SIG_W-1:0]  want_wx_footer;

  modport source (
    output valid, now_ms, on_weather_screen, full_request, want_header, want_status,
           want_gauge, want_footer, want_wx_now, want_wx_forecast, want_wx_footer,
    input  ready
  );
  modport sink (
    input  valid, now_ms, on_weather_screen, full_request, want_header, want_status,
           want_gauge, want_footer, want_wx_now, want_wx_forecast, want_wx_footer,
    output ready
  );
endinterface

interface dzrs_out_if import dzrs_pkg::*;;
  logic              valid;
  logic              ready;
  action_t           action;
  logic [ZONE_W-1:0] zone;

  modport source (output valid, action, zone, input ready);
  modport sink (input valid, action, zone, output ready);
endinterface

[rtl/core/display_zone_refresh_scheduler.sv]
// Zone refresh scheduler for a seven-zone e-paper panel.
// Accepted ticks are held in the input reg; their results are registered in the result reg.
// Throughput: one tick per cycle unless out_ch stalls; the zone compare and priority pick are combinational.
// Reset (rst_n low, synchronous): registers take their default intervals, zone state clears,
// a full refresh is pending and both channels come up empty.
module display_zone_refresh_scheduler import dzrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dzrs_in_if.sink              in_ch,
  dzrs_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  logic    s1_vld_r, s1_vld_nxt;
  tick_t   s1_r;
  tick_t   tick_in;
  logic    out_vld_r, out_vld_nxt;
  result_t out_r;
  result_t res;
  logic    advance;
  logic    en;
  logic    in_acc;

  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !s1_vld_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign en          = s1_vld_r && advance;

  always_comb begin
    tick_in.now_ms            = in_ch.now_ms;
    tick_in.on_weather_screen = in_ch.on_weather_screen;
    tick_in.full_request      = in_ch.full_request;
    tick_in.want[0]           = in_ch.want_header;
    tick_in.want[1]           = in_ch.want_status;
    tick_in.want[2]           = in_ch.want_gauge;
    tick_in.want[3]           = in_ch.want_footer;
    tick_in.want[4]           = in_ch.want_wx_now;
    tick_in.want[5]           = in_ch.want_wx_forecast;
    tick_in.want[6]           = in_ch.want_wx_footer;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HF_INTERVAL:     cfg_nxt.header_footer_interval_ms = cfg_wdata;
        CFG_STATUS_INTERVAL: cfg_nxt.status_interval_ms = cfg_wdata;
        CFG_GAUGE_INTERVAL:  cfg_nxt.gauge_interval_ms = cfg_wdata;
        CFG_FULL_INTERVAL:   cfg_nxt.full_ivl_ms = cfg_wdata;
        CFG_PARTIALS_MAX:    cfg_nxt.partials_max = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (en) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (en) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_footer_interval_ms <= TIME_W'(30000);
      cfg_r.status_interval_ms        <= TIME_W'(2000);
      cfg_r.gauge_interval_ms         <= TIME_W'(60000);
      cfg_r.full_ivl_ms               <= TIME_W'(600000);
      cfg_r.partials_max              <= CNT_W'(20);
      s1_vld_r                        <= 1'b0;
      out_vld_r                       <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= tick_in;
    end
    if (en) begin
      out_r <= res;
    end
  end

  dzrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tick  (s1_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_ch.valid  = out_vld_r;
  assign out_ch.action = out_r.action;
  assign out_ch.zone   = out_r.zone;

endmodule

[rtl/core/dzrs_core.sv]
`include "assert_macros.svh"

module dzrs_core import dzrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output result_t res
);

  logic [ZONES-1:0][SIG_W-1:0]  drawn_r, drawn_nxt;
  logic [ZONES-1:0][TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0]            last_full_r, last_full_nxt;
  logic [CNT_W-1:0]             pcount_r, pcount_nxt;
  logic                         full_pending_r, full_pending_nxt;
  logic                         wog_r, wog_nxt;

  logic                     wx;
  logic                     pend;
  logic [ZONES-1:0]         active;
  logic [ZONES-1:0]         dirty;
  logic [ZONES-1:0]         ripe;
  logic                     any_dirty;
  logic [TIME_W-1:0]        el_full;
  logic                     due;
  logic                     do_full;
  logic                     part_found;
  logic [ZONE_W-1:0]        part_zone;
  logic [TIME_W-1:0]        el_zone [ZONES];
  logic [TIME_W-1:0]        ivl [ZONES];

  assign wx   = tick.on_weather_screen;
  assign pend = full_pending_r | tick.full_request | (wx != wog_r);

  always_comb begin
    for (int i = 0; i < ZONES; i++) begin
      if (ZONE_W'(i) == ZONE_HEADER) begin
        active[i] = 1'b1;
      end else begin
        active[i] = (ZONE_W'(i) >= ZONE_FIRST_WX) == wx;
      end
      if (ZONE_W'(i) == ZONE_STATUS) begin
        ivl[i] = cfg.status_interval_ms;
      end else if (ZONE_W'(i) == ZONE_GAUGE) begin
        ivl[i] = cfg.gauge_interval_ms;
      end else begin
        ivl[i] = cfg.header_footer_interval_ms;
      end
      dirty[i]   = active[i] && (tick.want[i] != drawn_r[i]);
      el_zone[i] = tick.now_ms - last_r[i];
      ripe[i]    = dirty[i] && (el_zone[i] >= ivl[i]);
    end
  end

  assign any_dirty = |dirty;
  assign el_full   = tick.now_ms - last_full_r;
  assign due       = pend || (any_dirty && (el_full > cfg.full_ivl_ms)) ||
                     (pcount_r >= cfg.partials_max);
  assign do_full   = due && (any_dirty || pend);

  // lowest-numbered ripe zone wins
  always_comb begin
    part_found = 1'b0;
    part_zone  = ZONE_HEADER;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (ripe[i]) begin
        part_found = 1'b1;
        part_zone  = ZONE_W'(i);
      end
    end
  end

  always_comb begin
    res.action = ACT_NONE;
    res.zone   = ZONE_HEADER;
    if (do_full) begin
      res.action = ACT_FULL;
    end else if (part_found) begin
      res.action = ACT_PART;
      res.zone   = part_zone;
    end
  end

  always_comb begin
    drawn_nxt        = drawn_r;
    last_nxt         = last_r;
    last_full_nxt    = last_full_r;
    pcount_nxt       = pcount_r;
    full_pending_nxt = full_pending_r;
    wog_nxt          = wog_r;
    if (en) begin
      wog_nxt          = wx;
      full_pending_nxt = pend;
      if (do_full) begin
        for (int i = 0; i < ZONES; i++) begin
          if (active[i]) begin
            drawn_nxt[i] = tick.want[i];
            last_nxt[i]  = tick.now_ms;
          end
        end
        last_full_nxt    = tick.now_ms;
        pcount_nxt       = '0;
        full_pending_nxt = 1'b0;
      end else if (part_found) begin
        drawn_nxt[part_zone] = tick.want[part_zone];
        last_nxt[part_zone]  = tick.now_ms;
        if (pcount_r != PCOUNT_MAX) begin
          pcount_nxt = pcount_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawn_r        <= '0;
      last_r         <= '0;
      last_full_r    <= '0;
      pcount_r       <= '0;
      full_pending_r <= 1'b1;
      wog_r          <= 1'b0;
    end else begin
      drawn_r        <= drawn_nxt;
      last_r         <= last_nxt;
      last_full_r    <= last_full_nxt;
      pcount_r       <= pcount_nxt;
      full_pending_r <= full_pending_nxt;
      wog_r          <= wog_nxt;
    end
  end

  `ASSERT_NEXT(a_full_clears, en && do_full, !full_pending_r && (pcount_r == '0))
  `ASSERT_NEXT(a_pcount_sat, en && !do_full && part_found && (pcount_r == PCOUNT_MAX), pcount_r == PCOUNT_MAX)
  `ASSERT_NEXT(a_glass_follows, en, wog_r == $past(tick.on_weather_screen))
  `ASSERT_SAME(a_part_active, res.action == ACT_PART, (res.zone == ZONE_HEADER) || ((res.zone >= ZONE_FIRST_WX) == wx))

endmodule
